// ===== hw/rtl/plti_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plti_pkg: shared types and constants
// Table geometry, fixed-point widths, command and status codes for the
// piecewise linear interpolator.
// ----------------------------------------------------------------------------
package plti_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int DATA_W      = 32;
   localparam int FRAC_W      = 16;
   localparam int CNT_W       = 7;
   localparam int SEG_W       = 6;
   localparam int INDEX_W     = 6;
   localparam int STATUS_W    = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_INTERIOR = 2'd0,
      STATUS_BELOW    = 2'd1,
      STATUS_LAST     = 2'd2,
      STATUS_LOAD     = 2'd3
   } status_type;

endpackage
`default_nettype wire

// ===== hw/rtl/plti_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plti_table: breakpoint memory
// Two arrays of breakpoint abscissae and values, one write port and one
// read port with registered read data.
// ----------------------------------------------------------------------------
module plti_table (
   input  wire logic                            clock,
   input  wire logic                            wr_en,
   input  wire logic [plti_pkg::IDX_W-1:0]      wr_addr,
   input  wire logic signed [plti_pkg::DATA_W-1:0] wr_x,
   input  wire logic signed [plti_pkg::DATA_W-1:0] wr_y,
   input  wire logic [plti_pkg::IDX_W-1:0]      rd_addr,
   output logic signed [plti_pkg::DATA_W-1:0]   rd_x,
   output logic signed [plti_pkg::DATA_W-1:0]   rd_y
);

   logic signed [plti_pkg::DATA_W-1:0] x_mem [plti_pkg::TABLE_DEPTH];
   logic signed [plti_pkg::DATA_W-1:0] y_mem [plti_pkg::TABLE_DEPTH];
   logic signed [plti_pkg::DATA_W-1:0] rd_x_ff;
   logic signed [plti_pkg::DATA_W-1:0] rd_y_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         x_mem[wr_addr] <= wr_x;
         y_mem[wr_addr] <= wr_y;
      end
   end

   always_ff @(posedge clock) begin
      rd_x_ff <= x_mem[rd_addr];
      rd_y_ff <= y_mem[rd_addr];
   end

   assign rd_x = rd_x_ff;
   assign rd_y = rd_y_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/plti_divider.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// plti_divider: fraction divider
// Restoring shift-subtract divider giving floor(2^16 * num / den) for
// num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module plti_divider (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [plti_pkg::DATA_W-1:0]     dividend,
   input  wire logic [plti_pkg::DATA_W-1:0]     divisor,
   output logic                                 done,
   output logic [plti_pkg::FRAC_W-1:0]          quotient
);

   localparam int STEP_W = $clog2(plti_pkg::FRAC_W + 1);

   logic                           run_ff,  run_in;
   logic                           done_ff, done_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic [plti_pkg::DATA_W:0]      rem_ff,  rem_in;
   logic [plti_pkg::DATA_W-1:0]    den_ff,  den_in;
   logic [plti_pkg::FRAC_W-1:0]    quo_ff,  quo_in;
   logic [plti_pkg::DATA_W:0]      shifted;
   logic                           fits;

   always_comb begin
      shifted = {rem_ff[plti_pkg::DATA_W-1:0], 1'b0};
      fits    = (shifted >= {1'b0, den_ff});
      run_in  = run_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend};
         den_in  = divisor;
         quo_in  = '0;
      end else if (run_ff) begin
         rem_in  = fits ? (shifted - {1'b0, den_ff}) : shifted;
         quo_in  = {quo_ff[plti_pkg::FRAC_W-2:0], fits};
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(plti_pkg::FRAC_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

   // the remainder stays below the divisor between steps
   assert property (@(posedge clock) disable iff (reset)
      run_ff && !$past(start) |-> rem_ff < {1'b0, den_ff})
      else $error("divider remainder not below divisor");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !run_ff)
      else $error("divider done while still running");

   assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("divider done without a run");

endmodule
`default_nettype wire

// ===== hw/rtl/piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// piecewise_linear_table_interp: table-driven linear interpolator
// Scans a breakpoint table for the segment holding a query abscissa and
// blends the two neighbouring values with a 16-bit fraction.
// ----------------------------------------------------------------------------
// usage
//   req_ channel: a beat is taken when start is high and busy is low.
//   req_cmd load writes req_point_x / req_point_y at req_entry_index;
//   req_cmd query interpolates at req_query_x.
//   rsp_ channel: rsp_valid is high for exactly one cycle per item, with
//   rsp_value, rsp_segment and rsp_status; the receiver cannot stall.
//   csr_ channel: point_count write, taken on csr_valid and csr_ready;
//   write it only while the block is idle.
// sequence
//   load: result in the cycle after the beat, busy stays low, so loads may
//   be issued every cycle.
//   query: one table read per breakpoint examined, each a memory read state
//   (ST_READ) then a compare state (ST_CHECK); a clamped result is registered
//   when the compare stops the scan, an interior one first runs the divider
//   (one quotient bit per cycle), then the multiply and add states.
// reset
//   synchronous, clears the sequencer and sets point_count to 1; the table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module piecewise_linear_table_interp (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_cmd,
   input  wire logic [plti_pkg::INDEX_W-1:0]         req_entry_index,
   input  wire logic signed [plti_pkg::DATA_W-1:0]   req_point_x,
   input  wire logic signed [plti_pkg::DATA_W-1:0]   req_point_y,
   input  wire logic signed [plti_pkg::DATA_W-1:0]   req_query_x,
   output logic                                      rsp_valid,
   output logic signed [plti_pkg::DATA_W-1:0]        rsp_value,
   output logic [plti_pkg::SEG_W-1:0]                rsp_segment,
   output logic [plti_pkg::STATUS_W-1:0]             rsp_status,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [plti_pkg::CNT_W-1:0]           csr_data
);

   localparam int DW   = plti_pkg::DATA_W;
   localparam int FW   = plti_pkg::FRAC_W;
   localparam int IW   = plti_pkg::IDX_W;
   localparam int PW   = DW + 1 + FW + 1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CHECK,
      ST_DIV,
      ST_MUL,
      ST_ADD
   } state_type;

   state_type                     state_ff,   state_in;
   logic [plti_pkg::CNT_W-1:0]    count_ff,   count_in;
   logic [IW-1:0]                 k_ff,       k_in;
   logic signed [DW-1:0]          qx_ff,      qx_in;
   logic signed [DW-1:0]          prev_x_ff,  prev_x_in;
   logic signed [DW-1:0]          prev_y_ff,  prev_y_in;
   logic signed [DW-1:0]          y_hi_ff,    y_hi_in;
   logic signed [PW-1:0]          prod_ff,    prod_in;
   logic                          rsp_valid_ff,   rsp_valid_in;
   logic signed [DW-1:0]          rsp_value_ff,   rsp_value_in;
   logic [plti_pkg::SEG_W-1:0]    rsp_segment_ff, rsp_segment_in;
   plti_pkg::status_type          rsp_status_ff,  rsp_status_in;

   logic                          accept;
   logic                          wr_en;
   logic signed [DW-1:0]          rd_x;
   logic signed [DW-1:0]          rd_y;
   logic [IW-1:0]                 last_idx;
   logic signed [DW:0]            num_wide;
   logic signed [DW:0]            den_wide;
   logic signed [DW:0]            y_diff;
   logic signed [PW-1:0]          prod_shifted;
   logic                          div_start;
   logic                          div_done;
   logic [FW-1:0]                 div_quo;

   assign accept = start && (state_ff == ST_IDLE);
   assign wr_en  = accept && (req_cmd == plti_pkg::CMD_LOAD)
                   && (32'(req_entry_index) < plti_pkg::TABLE_DEPTH);

   plti_table u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (IW'(req_entry_index)),
      .wr_x    (req_point_x),
      .wr_y    (req_point_y),
      .rd_addr (k_ff),
      .rd_x    (rd_x),
      .rd_y    (rd_y)
   );

   always_comb begin
      if (count_ff == '0) begin
         last_idx = '0;
      end else if (32'(count_ff) > plti_pkg::TABLE_DEPTH) begin
         last_idx = IW'(plti_pkg::TABLE_DEPTH - 1);
      end else begin
         last_idx = IW'(count_ff - plti_pkg::CNT_W'(1));
      end
   end

   assign num_wide     = {qx_ff[DW-1], qx_ff} - {prev_x_ff[DW-1], prev_x_ff};
   assign den_wide     = {rd_x[DW-1], rd_x} - {prev_x_ff[DW-1], prev_x_ff};
   assign y_diff       = {y_hi_ff[DW-1], y_hi_ff} - {prev_y_ff[DW-1], prev_y_ff};
   assign prod_shifted = prod_ff >>> FW;

   plti_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_wide[DW-1:0]),
      .divisor  (den_wide[DW-1:0]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      k_in           = k_ff;
      qx_in          = qx_ff;
      prev_x_in      = prev_x_ff;
      prev_y_in      = prev_y_ff;
      y_hi_in        = y_hi_ff;
      prod_in        = prod_ff;
      rsp_valid_in   = 1'b0;
      rsp_value_in   = rsp_value_ff;
      rsp_segment_in = rsp_segment_ff;
      rsp_status_in  = rsp_status_ff;
      div_start      = 1'b0;
      if (csr_valid && csr_ready) begin
         count_in = csr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_cmd == plti_pkg::CMD_LOAD) begin
                  rsp_valid_in   = 1'b1;
                  rsp_value_in   = '0;
                  rsp_segment_in = '0;
                  rsp_status_in  = plti_pkg::STATUS_LOAD;
               end else begin
                  qx_in    = req_query_x;
                  k_in     = '0;
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (qx_ff < rd_x) begin
               if (k_ff == '0) begin
                  rsp_valid_in   = 1'b1;
                  rsp_value_in   = rd_y;
                  rsp_segment_in = '0;
                  rsp_status_in  = plti_pkg::STATUS_BELOW;
                  state_in       = ST_IDLE;
               end else begin
                  div_start      = 1'b1;
                  y_hi_in        = rd_y;
                  rsp_segment_in = plti_pkg::SEG_W'(k_ff - IW'(1));
                  state_in       = ST_DIV;
               end
            end else begin
               prev_x_in = rd_x;
               prev_y_in = rd_y;
               if (k_ff == last_idx) begin
                  rsp_valid_in   = 1'b1;
                  rsp_value_in   = rd_y;
                  rsp_segment_in = plti_pkg::SEG_W'(k_ff);
                  rsp_status_in  = plti_pkg::STATUS_LAST;
                  state_in       = ST_IDLE;
               end else begin
                  k_in     = k_ff + IW'(1);
                  state_in = ST_READ;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PW'(y_diff * $signed({1'b0, div_quo}));
            state_in = ST_ADD;
         end
         ST_ADD: begin
            rsp_valid_in  = 1'b1;
            rsp_value_in  = prev_y_ff + prod_shifted[DW-1:0];
            rsp_status_in = plti_pkg::STATUS_INTERIOR;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= plti_pkg::CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff           <= k_in;
      qx_ff          <= qx_in;
      prev_x_ff      <= prev_x_in;
      prev_y_ff      <= prev_y_in;
      y_hi_ff        <= y_hi_in;
      prod_ff        <= prod_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_segment_ff <= rsp_segment_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign busy        = (state_ff != ST_IDLE);
   assign csr_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_segment = rsp_segment_ff;
   assign rsp_status  = rsp_status_ff;

   assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == plti_pkg::CMD_QUERY) |=> busy && !rsp_valid)
      else $error("query beat did not start the scan");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_ff != plti_pkg::STATUS_LOAD) |-> $past(busy))
      else $error("query result without a scan");

   assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CHECK |-> k_ff <= last_idx)
      else $error("scan ran past the last breakpoint");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status_ff == plti_pkg::STATUS_LOAD) |-> rsp_value == '0)
      else $error("load result carries a value");

endmodule
`default_nettype wire

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking regression for piecewise_linear_table_interp
// A clocked driver sends load and query beats from a backlog queue. The
// stimulus covers directed corner cases, then randomly shaped tables under
// many point-count settings. A clocked monitor predicts every accepted beat
// from a local copy of the breakpoint table and point count, and checks
// each result strobe field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic                             cmd;
      logic [plti_pkg::INDEX_W-1:0]     index;
      logic [plti_pkg::DATA_W-1:0]      px;
      logic [plti_pkg::DATA_W-1:0]      py;
      logic [plti_pkg::DATA_W-1:0]      qx;
   } interp_req_type;

   typedef struct packed {
      logic [plti_pkg::DATA_W-1:0]      value;
      logic [plti_pkg::SEG_W-1:0]       segment;
      plti_pkg::status_type             status;
   } interp_result_type;

   localparam longint XMIN = -64'sd2147483648;
   localparam longint XMAX = 64'sd2147483647;
   localparam int RANDOM_BEATS = 1300;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = plti_pkg::CMD_LOAD;
   logic [plti_pkg::INDEX_W-1:0] req_entry_index = '0;
   logic signed [plti_pkg::DATA_W-1:0] req_point_x = '0;
   logic signed [plti_pkg::DATA_W-1:0] req_point_y = '0;
   logic signed [plti_pkg::DATA_W-1:0] req_query_x = '0;
   logic rsp_valid;
   logic signed [plti_pkg::DATA_W-1:0] rsp_value;
   logic [plti_pkg::SEG_W-1:0] rsp_segment;
   logic [plti_pkg::STATUS_W-1:0] rsp_status;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [plti_pkg::CNT_W-1:0] csr_data = '0;

   // predictor state
   logic [plti_pkg::DATA_W-1:0] tbl_x [plti_pkg::TABLE_DEPTH];
   logic [plti_pkg::DATA_W-1:0] tbl_y [plti_pkg::TABLE_DEPTH];
   logic [plti_pkg::CNT_W-1:0] cfg_points = 1;

   // stimulus-side view of the table
   longint gen_x [plti_pkg::TABLE_DEPTH];
   bit written [plti_pkg::TABLE_DEPTH];

   interp_req_type req_backlog[$];
   interp_result_type predicted_results[$];
   logic taken = 1'b0;
   int idle_pct = 15;
   int queued = 0;
   int mismatches = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int status_seen [4] = '{0, 0, 0, 0};

   piecewise_linear_table_interp u_top (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_cmd         (req_cmd),
      .req_entry_index (req_entry_index),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_query_x     (req_query_x),
      .rsp_valid       (rsp_valid),
      .rsp_value       (rsp_value),
      .rsp_segment     (rsp_segment),
      .rsp_status      (rsp_status),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_data        (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic interp_result_type interp_predict(interp_req_type it);
      interp_result_type r;
      int n;
      longint xq, x_lo, x_hi, y_lo, y_hi, sum;
      u64_type frac;
      r.value = '0;
      r.segment = '0;
      r.status = plti_pkg::STATUS_LOAD;
      if (it.cmd == plti_pkg::CMD_LOAD) begin
         tbl_x[it.index] = it.px;
         tbl_y[it.index] = it.py;
         return r;
      end
      n = (cfg_points == 0) ? 1 :
          (cfg_points > plti_pkg::TABLE_DEPTH) ? plti_pkg::TABLE_DEPTH : int'(cfg_points);
      xq = longint'($signed(it.qx));
      if (xq < longint'($signed(tbl_x[0]))) begin
         r.value = tbl_y[0];
         r.status = plti_pkg::STATUS_BELOW;
         return r;
      end
      for (int k = 0; k + 1 < n; k++) begin
         x_lo = longint'($signed(tbl_x[k]));
         x_hi = longint'($signed(tbl_x[k + 1]));
         if (xq < x_hi) begin
            y_lo = longint'($signed(tbl_y[k]));
            y_hi = longint'($signed(tbl_y[k + 1]));
            frac = u64_type'(xq - x_lo) << 16;
            frac = frac / u64_type'(x_hi - x_lo);
            if (frac > 65535) frac = 65535;
            sum = y_lo * (65536 - longint'(frac)) + y_hi * longint'(frac);
            sum = sum >>> 16;
            r.value = sum[plti_pkg::DATA_W-1:0];
            r.segment = k[plti_pkg::SEG_W-1:0];
            r.status = plti_pkg::STATUS_INTERIOR;
            return r;
         end
      end
      r.value = tbl_y[n - 1];
      r.segment = plti_pkg::SEG_W'(n - 1);
      r.status = plti_pkg::STATUS_LAST;
      return r;
   endfunction

   // driver: new beat at the falling edge once the previous one is taken
   always @(negedge clock) begin
      interp_req_type nxt;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
            nxt = req_backlog.pop_front();
            start <= 1'b1;
            req_cmd <= nxt.cmd;
            req_entry_index <= nxt.index;
            req_point_x <= nxt.px;
            req_point_y <= nxt.py;
            req_query_x <= nxt.qx;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor: predicts accepted beats and checks result strobes
   always @(posedge clock) begin
      interp_req_type seen;
      interp_result_type want;
      if (reset) begin
         taken <= 1'b0;
         cfg_points = 1;
      end else begin
         taken <= start && !busy;
         if (csr_valid && csr_ready) cfg_points = csr_data;
         if (rsp_valid) begin
            if (predicted_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h seg %0d status %0d",
                        $time, rsp_value, rsp_segment, rsp_status);
               mismatches++;
            end else begin
               want = predicted_results.pop_front();
               results_checked++;
               status_seen[rsp_status]++;
               if (rsp_value !== want.value) begin
                  $display("%0t: value mismatch, expected %h, actual %h",
                           $time, want.value, rsp_value);
                  mismatches++;
               end
               if (rsp_segment !== want.segment) begin
                  $display("%0t: segment mismatch, expected %0d, actual %0d",
                           $time, want.segment, rsp_segment);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, want.status, rsp_status);
                  mismatches++;
               end
            end
         end
         if (start && !busy) begin
            seen.cmd = req_cmd;
            seen.index = req_entry_index;
            seen.px = req_point_x;
            seen.py = req_point_y;
            seen.qx = req_query_x;
            predicted_results.insert(predicted_results.size(), interp_predict(seen));
         end
      end
   end

   task automatic push_load(input int idx, input longint x, input longint y);
      interp_req_type it;
      it.cmd = plti_pkg::CMD_LOAD;
      it.index = idx[plti_pkg::INDEX_W-1:0];
      it.px = x[plti_pkg::DATA_W-1:0];
      it.py = y[plti_pkg::DATA_W-1:0];
      it.qx = $urandom;
      req_backlog.insert(req_backlog.size(), it);
      gen_x[idx] = longint'($signed(x[plti_pkg::DATA_W-1:0]));
      written[idx] = 1'b1;
      queued++;
   endtask

   task automatic push_query(input longint x);
      interp_req_type it;
      if (x < XMIN) x = XMIN;
      if (x > XMAX) x = XMAX;
      it.cmd = plti_pkg::CMD_QUERY;
      it.index = plti_pkg::INDEX_W'($urandom);
      it.px = $urandom;
      it.py = $urandom;
      it.qx = x[plti_pkg::DATA_W-1:0];
      req_backlog.insert(req_backlog.size(), it);
      queued++;
   endtask

   function automatic longint random_y();
      case ($urandom_range(0, 5))
         0: return XMIN;
         1: return XMAX;
         2: return longint'(int'($urandom_range(0, 2000)) - 1000);
         default: return longint'($signed($urandom));
      endcase
   endfunction

   task automatic push_random_query(input int n);
      int k;
      longint x;
      k = $urandom_range(0, n - 1);
      case ($urandom_range(0, 9))
         0, 1: x = longint'($signed($urandom));
         2: x = gen_x[k];
         3: x = gen_x[k] - 1;
         4: x = gen_x[k] + 1;
         5: x = $urandom_range(0, 1) ? XMIN : XMAX;
         default: begin
            if (n == 1) begin
               x = longint'($signed($urandom));
            end else begin
               if (k == n - 1) k--;
               if (gen_x[k + 1] > gen_x[k])
                  x = gen_x[k] + longint'($urandom) % (gen_x[k + 1] - gen_x[k]);
               else
                  x = gen_x[k];
            end
         end
      endcase
      push_query(x);
   endtask

   // mostly ascending tables, sometimes scrambled
   task automatic fill_table(input int n);
      int shape;
      longint cur, stepmax;
      shape = $urandom_range(0, 9);
      case ($urandom_range(0, 2))
         0: begin
            cur = longint'(int'($urandom_range(0, 200)) - 100);
            stepmax = 4;
         end
         1: begin
            cur = longint'($signed($urandom));
            stepmax = 64'h4_0000;
         end
         default: begin
            cur = XMIN + longint'($urandom_range(0, 1000));
            stepmax = 64'h1_0000_0000 / n;
         end
      endcase
      for (int k = 0; k < n; k++) begin
         if (shape == 0) cur = longint'($signed($urandom));
         push_load(k, cur, random_y());
         if (shape != 0) begin
            cur += longint'($urandom) % (stepmax + 1);
            if (cur > XMAX) cur = XMAX;
         end
      end
   endtask

   task automatic wait_drain();
      while (req_backlog.size() != 0 || start || predicted_results.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic csr_write(input logic [plti_pkg::CNT_W-1:0] v);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_writes++;
   endtask

   initial begin
      int phase_counts [14];
      int directed_total, ph, cnt, n, idx;
      bit complete;
      phase_counts = '{2, 64, 3, 127, 8, 1, 65, 16, 0, 33, 64, 5, 100, 2};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-point table, reset count
      push_load(0, 0, XMIN);
      push_query(-1);
      push_query(0);
      push_query(XMAX);
      push_query(XMIN);
      wait_drain();
      // zero count behaves as one
      csr_write(0);
      push_query(5);
      wait_drain();
      csr_write(4);
      // equal breakpoints at 1.0, last at the top of the range
      push_load(1, 65536, XMAX);
      push_load(2, 65536, 0);
      push_load(3, XMAX, 32'h1234_5678);
      push_query(32768);
      push_query(65535);
      push_query(65536);
      push_query(XMAX - 1);
      push_query(XMAX);
      // wide first segment starting at the bottom of the range
      push_load(0, XMIN, XMAX);
      push_query(XMIN);
      push_query(0);
      // descending breakpoint in the middle
      push_load(2, -1048576, -5);
      push_query(131072);
      push_query(-1048577);
      directed_total = queued;

      ph = 0;
      while (queued - directed_total < RANDOM_BEATS) begin
         wait_drain();
         cnt = phase_counts[ph % 14];
         csr_write(cnt[plti_pkg::CNT_W-1:0]);
         n = (cnt == 0) ? 1 : (cnt > plti_pkg::TABLE_DEPTH) ? plti_pkg::TABLE_DEPTH : cnt;
         idle_pct = (ph == 3) ? 0 : 15;
         complete = 1'b1;
         for (int k = 0; k < n; k++)
            if (!written[k]) complete = 1'b0;
         if (!complete || $urandom_range(0, 3) != 0) fill_table(n);
         for (int j = 0; j < 90; j++) begin
            if ($urandom_range(0, 99) < 15) begin
               if (n < plti_pkg::TABLE_DEPTH && $urandom_range(0, 2) != 0)
                  idx = $urandom_range(n, plti_pkg::TABLE_DEPTH - 1);
               else
                  idx = $urandom_range(0, plti_pkg::TABLE_DEPTH - 1);
               push_load(idx, longint'($signed($urandom)), random_y());
            end else begin
               push_random_query(n);
            end
         end
         ph++;
      end

      wait_drain();
      repeat (200) @(posedge clock);
      if (predicted_results.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, predicted_results.size());
         mismatches++;
      end
      $display("checked %0d results: %0d loads, %0d interior, %0d below, %0d last",
               results_checked, status_seen[plti_pkg::STATUS_LOAD],
               status_seen[plti_pkg::STATUS_INTERIOR],
               status_seen[plti_pkg::STATUS_BELOW], status_seen[plti_pkg::STATUS_LAST]);
      $display("%0d point-count settings, %0d random table phases, %0d mismatches",
               csr_writes, ph, mismatches);
      if (mismatches == 0)
         $display("piecewise_linear_table_interp regression: pass");
      else
         $display("piecewise_linear_table_interp regression: fail");
      $finish;
   end

   // watchdog
   initial begin
      #20_000_000;
      $display("piecewise_linear_table_interp regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/plti_pkg.sv
hw/rtl/plti_table.sv
hw/rtl/plti_divider.sv
hw/rtl/piecewise_linear_table_interp.sv
verif/testbench.sv
